### sv/all_pairs_shortest_path_assert.svh
// ----------------------------------------------------------------------------
// All-pairs shortest path: assertion macros
// Clocked assertion shorthands, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define APSP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define APSP_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

  // Default sizing
  localparam int unsigned MAX_NODES_DEF   = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned NODE_IDX_W = 4;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned NODE_CNT_W = 5;

  // node_count after reset
  localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // Request transaction
  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [NODE_IDX_W-1:0] row;
    logic [NODE_IDX_W-1:0] col;
    logic [WEIGHT_W-1:0]   weight;
    logic                  has_edge;
  } in_item_t;

  // Response transaction
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              done_res;
  } out_item_t;

  typedef logic [NODE_CNT_W-1:0] cfg_item_t;

endpackage

`default_nettype wire

### sv/apsp_stream_if.sv
// ----------------------------------------------------------------------------
// apsp_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface apsp_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### sv/apsp_ram.sv
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_ram #(
  parameter int unsigned WIDTH = apsp_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned DEPTH = apsp_pkg::MAX_NODES_DEF * apsp_pkg::MAX_NODES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/all_pairs_shortest_path.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Edge store, distance store and a sequencer running a shortest path closure.
// ----------------------------------------------------------------------------
// After reset the edge store is swept clear, one entry per cycle, over all
// MAX_NODES*MAX_NODES entries; no request is taken meanwhile, configuration
// writes are. A write request is answered from ST_IDLE, a read request from
// ST_RDOUT after a registered memory read. A run request builds the distance
// matrix over n = node_count nodes in ST_INIT and ST_INIT_END and then relaxes
// it in passes until a pass changes nothing (at least one pass). A pass fetches
// d[i][j] for each node pair (i,j) in ST_DIJ and ST_DIJW and, when d[i][j] is
// reachable, steps k over the n nodes in ST_KLOOP: one relaxation per cycle
// through a single add/compare unit fed by the two read ports of the distance
// store. The block holds one request at a time and takes the next one when its
// response has been handed off or leaves the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "all_pairs_shortest_path_assert.svh"

module all_pairs_shortest_path #(
  parameter int unsigned MAX_NODES   = apsp_pkg::MAX_NODES_DEF,
  parameter int unsigned WEIGHT_BITS = apsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  apsp_stream_if.sink   cfg_i,
  apsp_stream_if.sink   item_i,
  apsp_stream_if.source res_o
);

  import apsp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CELLS = MAX_NODES * MAX_NODES;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned WB    = WEIGHT_BITS;
  localparam int unsigned CW    = (IDX_W + 1 > NODE_CNT_W) ? IDX_W + 1 : NODE_CNT_W;

  localparam logic [WB-1:0] UNREACH = '1;
  localparam logic [WB-1:0] SAT_MAX = UNREACH - 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_RDOUT    = 8'b0000_0100,
    ST_INIT     = 8'b0000_1000,
    ST_INIT_END = 8'b0001_0000,
    ST_DIJ      = 8'b0010_0000,
    ST_DIJW     = 8'b0100_0000,
    ST_KLOOP    = 8'b1000_0000
  } state_e;

  // Linear cell address of (r, c)
  function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
    logic [AW-1:0] base;
    base = AW'(r) * AW'(MAX_NODES);
    return base + AW'(c);
  endfunction

  // Registers
  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [IDX_W-1:0]      i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0]      nm1_q, nm1_d;
  logic [NODE_CNT_W-1:0] nc_q;
  logic                  changed_q, changed_d;
  logic                  ran_q, ran_d;
  logic [WB-1:0]         dij_q, dij_d;
  logic                  init_pend_q, init_pend_d;
  logic [AW-1:0]         init_addr_q, init_addr_d;
  logic                  init_diag_q, init_diag_d;
  logic                  rd_hit_q, rd_hit_d;
  logic                  out_vld_q, out_vld_d;
  out_item_t             out_q, out_d;

  // Request decode
  in_item_t         req;
  opcode_e          op;
  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] req_row, req_col;
  logic [AW-1:0]    req_cell;
  logic [WB-1:0]    w_in, w_st;
  logic             rd_hit;

  assign req      = item_i.data;
  assign op       = opcode_e'(req.opcode);
  assign accept   = item_i.valid && item_i.ready;
  assign in_range = (32'(req.row) < MAX_NODES) && (32'(req.col) < MAX_NODES);
  assign req_row  = IDX_W'(req.row);
  assign req_col  = IDX_W'(req.col);
  assign req_cell = cell_addr(req_row, req_col);
  assign w_in     = WB'(req.weight);
  assign w_st     = (w_in == UNREACH) ? SAT_MAX : w_in;
  assign rd_hit   = in_range && ran_q && (req_row <= nm1_q) && (req_col <= nm1_q);

  // Effective node count minus one from the config register
  logic [CW-1:0]    nc_ext;
  logic [IDX_W-1:0] n_m1_cfg;

  assign nc_ext = CW'(nc_q);
  always_comb begin
    if (nc_q == '0) begin
      n_m1_cfg = '0;
    end else if (nc_ext > CW'(MAX_NODES)) begin
      n_m1_cfg = IDX_W'(MAX_NODES - 1);
    end else begin
      n_m1_cfg = IDX_W'(nc_ext - 1'b1);
    end
  end

  // Memories
  logic          edge_we;
  logic [AW-1:0] edge_waddr;
  logic [WB:0]   edge_wdata, edge_rdata;
  logic          dist_we;
  logic [AW-1:0] dist_waddr, a_raddr, b_raddr;
  logic [WB-1:0] dist_wdata, a_rdata, b_rdata;

  apsp_ram #(.WIDTH(WB + 1), .DEPTH(CELLS)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (cell_addr(i_q, j_q)),
    .rdata_o (edge_rdata)
  );

  // Two copies of the distance store, written together, read at d[i][*] and d[j][*]
  apsp_ram #(.WIDTH(WB), .DEPTH(CELLS)) u_dist_a_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  apsp_ram #(.WIDTH(WB), .DEPTH(CELLS)) u_dist_b_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Edge store writes: clearing sweep or write transaction
  always_comb begin
    if (state_q == ST_CLEAR) begin
      edge_we    = 1'b1;
      edge_waddr = clr_q;
      edge_wdata = '0;
    end else begin
      edge_we    = accept && (op == OP_WRITE) && in_range;
      edge_waddr = req_cell;
      edge_wdata = {req.has_edge, req.has_edge ? w_st : {WB{1'b0}}};
    end
  end

  // Shared relaxation unit: saturating add and compare
  logic [WB:0]   sum;
  logic [WB-1:0] sat_sum;
  logic          upd;

  assign sum     = {1'b0, b_rdata} + {1'b0, dij_q};
  assign sat_sum = (sum > {1'b0, SAT_MAX}) ? SAT_MAX : sum[WB-1:0];
  assign upd     = (state_q == ST_KLOOP) && (b_rdata != UNREACH) && (sat_sum < a_rdata);

  // Distance store writes: initial fill or relaxation
  always_comb begin
    if (init_pend_q) begin
      dist_we    = 1'b1;
      dist_waddr = init_addr_q;
      if (edge_rdata[WB]) begin
        dist_wdata = edge_rdata[WB-1:0];
      end else begin
        dist_wdata = init_diag_q ? '0 : UNREACH;
      end
    end else begin
      dist_we    = upd;
      dist_waddr = cell_addr(i_q, k_q);
      dist_wdata = sat_sum;
    end
  end

  // Read addresses of the distance store
  logic [IDX_W-1:0] k_next;

  assign k_next = ((state_q == ST_DIJW) || (k_q == nm1_q)) ? '0 : k_q + 1'b1;

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        a_raddr = req_cell;
      end
      ST_DIJ: begin
        a_raddr = cell_addr(i_q, j_q);
      end
      default: begin
        a_raddr = cell_addr(i_q, k_next);
      end
    endcase
  end

  assign b_raddr = cell_addr(j_q, k_next);

  // Read response value
  logic [WB-1:0] rd_dist;

  assign rd_dist = rd_hit_q ? a_rdata : UNREACH;

  // Sequencer
  logic last_i, last_j, pair_adv, out_load;

  assign last_i = (i_q == nm1_q);
  assign last_j = (j_q == nm1_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    nm1_d       = nm1_q;
    changed_d   = changed_q | upd;
    ran_d       = ran_q;
    dij_d       = dij_q;
    init_pend_d = 1'b0;
    init_addr_d = init_addr_q;
    init_diag_d = init_diag_q;
    rd_hit_d    = rd_hit_q;
    pair_adv    = 1'b0;
    out_load    = 1'b0;
    out_d       = out_q;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_WRITE: begin
              out_load = 1'b1;
              out_d    = '{distance: '0, reachable: 1'b0, done_res: 1'b1};
            end
            OP_READ: begin
              rd_hit_d = rd_hit;
              state_d  = ST_RDOUT;
            end
            OP_RUN: begin
              nm1_d     = n_m1_cfg;
              i_d       = '0;
              j_d       = '0;
              changed_d = 1'b0;
              state_d   = ST_INIT;
            end
            default: begin
              out_load = 1'b1;
              out_d    = '0;
            end
          endcase
        end
      end
      ST_RDOUT: begin
        out_load = 1'b1;
        out_d    = '{distance: DIST_W'(rd_dist), reachable: (rd_dist != UNREACH),
                     done_res: 1'b0};
        state_d  = ST_IDLE;
      end
      ST_INIT: begin
        // edge entry is read now and lands in the distance store next cycle
        init_pend_d = 1'b1;
        init_addr_d = cell_addr(i_q, j_q);
        init_diag_d = (i_q == j_q);
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            i_d     = '0;
            state_d = ST_INIT_END;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_INIT_END: begin
        state_d = ST_DIJ;
      end
      ST_DIJ: begin
        state_d = ST_DIJW;
      end
      ST_DIJW: begin
        dij_d = a_rdata;
        if (a_rdata == UNREACH) begin
          pair_adv = 1'b1;
        end else begin
          k_d     = '0;
          state_d = ST_KLOOP;
        end
      end
      ST_KLOOP: begin
        if (k_q == nm1_q) begin
          pair_adv = 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Next (i,j) pair, pass end check
    if (pair_adv) begin
      state_d = ST_DIJ;
      if (!last_j) begin
        j_d = j_q + 1'b1;
      end else begin
        j_d = '0;
        if (!last_i) begin
          i_d = i_q + 1'b1;
        end else begin
          i_d = '0;
          if (changed_q || upd) begin
            changed_d = 1'b0;
          end else begin
            ran_d    = 1'b1;
            out_load = 1'b1;
            out_d    = '{distance: '0, reachable: 1'b0, done_res: 1'b1};
            state_d  = ST_IDLE;
          end
        end
      end
    end
  end

  // Output register
  assign out_vld_d    = out_load || (out_vld_q && !res_o.ready);
  assign res_o.valid  = out_vld_q;
  assign res_o.data   = out_q;
  assign item_i.ready = (state_q == ST_IDLE) && (!out_vld_q || res_o.ready);
  assign cfg_i.ready  = 1'b1;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      nm1_q       <= '0;
      nc_q        <= NODE_CNT_RST;
      changed_q   <= 1'b0;
      ran_q       <= 1'b0;
      init_pend_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      nm1_q       <= nm1_d;
      changed_q   <= changed_d;
      ran_q       <= ran_d;
      init_pend_q <= init_pend_d;
      out_vld_q   <= out_vld_d;
      if (cfg_i.valid) begin
        nc_q <= cfg_i.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dij_q       <= dij_d;
    init_addr_q <= init_addr_d;
    init_diag_q <= init_diag_d;
    rd_hit_q    <= rd_hit_d;
    out_q       <= out_d;
  end

  // Assertions
  `APSP_ASSERT_IMP(a_no_req_in_clear, state_q == ST_CLEAR, !item_i.ready,
                   "request taken during edge store clear")
  `APSP_ASSERT_IMP(a_load_free_slot, out_load, !out_vld_q || res_o.ready,
                   "response overwrites a pending response")
  `APSP_ASSERT_IMP(a_idx_in_range, state_q == ST_KLOOP,
                   (k_q <= nm1_q) && (i_q <= nm1_q) && (j_q <= nm1_q),
                   "relaxation index beyond node count")
  `APSP_ASSERT_NXT(a_run_starts_init, accept && (op == OP_RUN), state_q == ST_INIT,
                   "run transaction did not start the initial fill")
  `APSP_ASSERT_IMP(a_no_write_clash, init_pend_q, !upd,
                   "initial fill and relaxation write at once")

endmodule

`default_nettype wire
